FILE: rtl/core/rstu_pkg.sv
// rstu_pkg: shared types, constants and digit decoding for the radix string parser
// depends on nothing; every other file in rtl/core uses it by scoped names
`timescale 1ns / 1ps

package rstu_pkg;

   // default widths handed to the top level parameters
   localparam int VALUE_WIDTH_DEF    = 32;
   localparam int POSITION_WIDTH_DEF = 16;

   // fixed field widths
   localparam int CHAR_WIDTH   = 8;
   localparam int RADIX_WIDTH  = 6;
   localparam int STATUS_WIDTH = 2;

   // radix register value after reset
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BASE  = 2'd2;

   // one character of the string
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  string_start;
   } char_item_type;

   // registered request handed from the input stage to the parser
   typedef struct packed {
      logic          valid;
      char_item_type item;
   } item_stage_type;

   // decoded digit: ok when the character is 0-9, a-z or A-Z
   typedef struct packed {
      logic                   ok;
      logic [RADIX_WIDTH-1:0] value;
   } digit_type;

   function automatic digit_type digit_decode(input logic [CHAR_WIDTH-1:0] c);
      digit_type             d;
      logic [CHAR_WIDTH-1:0] t;
      d.ok    = 1'b0;
      d.value = '0;
      t       = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t       = c - 8'h41 + 8'd10;
         d.ok    = 1'b1;
         d.value = t[RADIX_WIDTH-1:0];
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t       = c - 8'h61 + 8'd10;
         d.ok    = 1'b1;
         d.value = t[RADIX_WIDTH-1:0];
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t       = c - 8'h30;
         d.ok    = 1'b1;
         d.value = t[RADIX_WIDTH-1:0];
      end
      return d;
   endfunction

endpackage

FILE: rtl/core/rstu_if.sv
// rstu channel interfaces: request, response and radix register write
// depends on rstu_pkg for field widths
`timescale 1ns / 1ps

// character request channel
interface rstu_req_if;
   logic                             valid;
   logic                             ready;
   logic [rstu_pkg::CHAR_WIDTH-1:0]  char_code;
   logic                             string_start;

   modport source (output valid, output char_code, output string_start, input ready);
   modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

// parse result channel
interface rstu_rsp_if #(
   parameter int VALUE_WIDTH    = rstu_pkg::VALUE_WIDTH_DEF,
   parameter int POSITION_WIDTH = rstu_pkg::POSITION_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [VALUE_WIDTH-1:0]            parsed_value;
   logic [rstu_pkg::STATUS_WIDTH-1:0] parse_status;
   logic [POSITION_WIDTH-1:0]         end_position;

   modport source (output valid, output parsed_value, output parse_status,
                   output end_position, input ready);
   modport sink   (input valid, input parsed_value, input parse_status,
                   input end_position, output ready);
endinterface

// radix register write channel
interface rstu_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rstu_pkg::RADIX_WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/radix_string_to_unsigned_parse.sv
// radix_string_to_unsigned_parse: streaming strtoul-style parser, top level
// depends on rstu_pkg, rstu_if, rstu_req_stage and rstu_parse_core
`timescale 1ns / 1ps

// Takes a string one character per request, string_start marking the first
// character, and returns one result per terminated string: the unsigned value
// (negated modulo 2^VALUE_WIDTH after a minus sign, all ones on overflow), a
// status (ok, range overflow, invalid base) and the index of the first
// unconsumed character. The radix register (0 auto, 2..36) is sampled on each
// start character and should be written only while no string is in flight.
// One character is accepted every cycle while the result register is not stalled;
// a terminating character is held in the input register and the base multiply-add
// loads its result into the result register.
// A stalled result does not stop the next characters while the input register
// has room. A restarted or unterminated string gives no result.
module radix_string_to_unsigned_parse #(
   parameter int VALUE_WIDTH    = rstu_pkg::VALUE_WIDTH_DEF,
   parameter int POSITION_WIDTH = rstu_pkg::POSITION_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rstu_req_if.sink   req_if,
   rstu_rsp_if.source rsp_if,
   rstu_csr_if.sink   csr_if
);

   rstu_pkg::item_stage_type stage;
   logic                     take;

   // input register
   rstu_req_stage u_req_stage (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .take   (take),
      .stage  (stage)
   );

   // parser and result register
   rstu_parse_core #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .take   (take),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

endmodule

FILE: rtl/core/rstu_req_stage.sv
// rstu_req_stage: input register for the character request channel
// depends on rstu_pkg and rstu_req_if
`timescale 1ns / 1ps

module rstu_req_stage (
   input  logic                     clock,
   input  logic                     reset,
   rstu_req_if.sink                 req_if,
   input  logic                     take,
   output rstu_pkg::item_stage_type stage
);

   logic                    valid_ff, valid_in;
   rstu_pkg::char_item_type item_ff;
   logic                    accept;

   // accept a new request whenever the register empties this cycle
   assign req_if.ready = !valid_ff || take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.char_code    <= req_if.char_code;
         item_ff.string_start <= req_if.string_start;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: rtl/core/rstu_parse_core.sv
// rstu_parse_core: parse state, digit multiply-accumulate and result register
// depends on rstu_pkg, rstu_rsp_if and rstu_csr_if
`timescale 1ns / 1ps

module rstu_parse_core #(
   parameter int VALUE_WIDTH    = rstu_pkg::VALUE_WIDTH_DEF,
   parameter int POSITION_WIDTH = rstu_pkg::POSITION_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rstu_pkg::item_stage_type stage,
   output logic                     take,
   rstu_rsp_if.source               rsp_if,
   rstu_csr_if.sink                 csr_if
);

   localparam int RW = rstu_pkg::RADIX_WIDTH;
   localparam int PW = VALUE_WIDTH + RW + 1;

   localparam logic [RW-1:0] BASE_AUTO = 6'd0;
   localparam logic [RW-1:0] BASE_ONE  = 6'd1;
   localparam logic [RW-1:0] BASE_MAX  = 6'd36;
   localparam logic [RW-1:0] BASE_OCT  = 6'd8;
   localparam logic [RW-1:0] BASE_DEC  = 6'd10;
   localparam logic [RW-1:0] BASE_HEX  = 6'd16;

   localparam logic [7:0] CH_WS_LO = 8'd9;
   localparam logic [7:0] CH_WS_HI = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h78;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_LEAD   = 5'b00010,
      PH_PREFIX = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   // parse state
   phase_type                phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0]   acc_ff, acc_in;
   logic [RW-1:0]            base_ff, base_in;
   logic                     minus_ff, minus_in;
   logic                     ovf_ff, ovf_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [RW-1:0]            radix_ff, radix_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]            value_ff;
   logic [rstu_pkg::STATUS_WIDTH-1:0] status_ff;
   logic [POSITION_WIDTH-1:0]         epos_ff;

   // working values for the character under way
   logic                              start, bad_base, emit;
   logic [7:0]                        c;
   phase_type                         cur_phase;
   logic [VALUE_WIDTH-1:0]            cur_acc;
   logic [RW-1:0]                     cur_base, dig_base;
   logic                              cur_minus, cur_ovf;
   logic [POSITION_WIDTH-1:0]         cur_pos;
   rstu_pkg::digit_type               dig;
   logic [PW-1:0]                     prod;
   logic                              prod_ovf, dig_end;
   logic [VALUE_WIDTH-1:0]            emit_value;
   logic [rstu_pkg::STATUS_WIDTH-1:0] emit_status;

   // the parser moves whenever the result register can hold what comes out
   assign take = stage.valid && (!rsp_valid_ff || rsp_if.ready);

   // radix register, always writable
   assign csr_if.ready = 1'b1;
   assign radix_in     = (csr_if.valid) ? csr_if.data : radix_ff;

   // start byte restarts from clean state with the latched radix
   always_comb begin
      c         = stage.item.char_code;
      start     = stage.item.string_start;
      bad_base  = (radix_ff == BASE_ONE) || (radix_ff > BASE_MAX);
      cur_phase = start ? PH_LEAD : phase_ff;
      cur_acc   = start ? '0 : acc_ff;
      cur_base  = start ? radix_ff : base_ff;
      cur_minus = start ? 1'b0 : minus_ff;
      cur_ovf   = start ? 1'b0 : ovf_ff;
      cur_pos   = start ? '0 : pos_ff;
   end

   // base in force for a digit, auto mode settled by the phase
   always_comb begin
      dig_base = cur_base;
      if (cur_base == BASE_AUTO) begin
         if (cur_phase == PH_ZERO) begin
            dig_base = BASE_OCT;
         end else begin
            dig_base = BASE_DEC;
         end
      end
   end

   // one multiply-add by the base, overflow from the full product
   always_comb begin
      dig      = rstu_pkg::digit_decode(c);
      prod     = PW'(cur_acc) * PW'(dig_base) + PW'(dig.value);
      prod_ovf = |prod[PW-1:VALUE_WIDTH];
      dig_end  = !dig.ok || (dig.value >= dig_base);
   end

   // value delivered when the number ends
   always_comb begin
      if (cur_ovf) begin
         emit_value  = '1;
         emit_status = rstu_pkg::ST_RANGE;
      end else begin
         emit_value  = cur_minus ? ('0 - cur_acc) : cur_acc;
         emit_status = rstu_pkg::ST_OK;
      end
   end

   // next parse state
   always_comb begin
      phase_in = cur_phase;
      acc_in   = cur_acc;
      base_in  = cur_base;
      minus_in = cur_minus;
      ovf_in   = cur_ovf;
      pos_in   = cur_pos;
      emit     = 1'b0;

      unique case (cur_phase)
         PH_LEAD, PH_PREFIX, PH_ZERO, PH_DIGITS: begin
            if (cur_phase == PH_LEAD &&
                ((c >= CH_WS_LO && c <= CH_WS_HI) || c == CH_SPACE)) begin
               // leading whitespace is skipped
            end else if (cur_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
               minus_in = (c == CH_MINUS);
               phase_in = PH_PREFIX;
            end else if (cur_phase != PH_ZERO && cur_phase != PH_DIGITS &&
                         c == CH_ZERO &&
                         (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
               phase_in = PH_ZERO;
            end else if (cur_phase == PH_ZERO && c == CH_X) begin
               base_in  = BASE_HEX;
               phase_in = PH_DIGITS;
            end else begin
               // digit or terminator in the settled base
               base_in = dig_base;
               if (dig_end) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_DIGITS;
                  if (!cur_ovf) begin
                     if (prod_ovf) begin
                        ovf_in = 1'b1;
                        acc_in = '1;
                     end else begin
                        acc_in = prod[VALUE_WIDTH-1:0];
                     end
                  end
               end
            end
            if (cur_pos != '1) begin
               pos_in = cur_pos + 1'b1;
            end
         end
         default: begin
            // idle: characters ignored until the next start
         end
      endcase

      // invalid base answers at once on the start byte
      if (start && bad_base) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         base_in  = cur_base;
         minus_in = 1'b0;
         ovf_in   = 1'b0;
         pos_in   = '0;
         emit     = 1'b1;
      end
   end

   // result register valid
   always_comb begin
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         base_ff      <= '0;
         minus_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         radix_ff     <= rstu_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            base_ff  <= base_in;
            minus_ff <= minus_in;
            ovf_ff   <= ovf_in;
            pos_ff   <= pos_in;
         end
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (take && emit) begin
         if (start && bad_base) begin
            value_ff  <= '0;
            status_ff <= rstu_pkg::ST_BASE;
            epos_ff   <= '0;
         end else begin
            value_ff  <= emit_value;
            status_ff <= emit_status;
            epos_ff   <= cur_pos;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.parsed_value = value_ff;
   assign rsp_if.parse_status = status_ff;
   assign rsp_if.end_position = epos_ff;

   // a sticky overflow always holds the saturated accumulator
   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (acc_ff == '1))
      else $error("overflow flag set without saturated accumulator");

   // invalid base on a start byte gives a base error result next cycle
   a_bad_base_result: assert property (@(posedge clock) disable iff (reset)
      (take && start && bad_base) |=>
         (rsp_valid_ff && status_ff == rstu_pkg::ST_BASE && value_ff == '0 &&
          epos_ff == '0))
      else $error("invalid base did not give a base error result");

   // an idle character leaves the position counter untouched
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (take && !start && phase_ff == PH_IDLE) |=> $stable(pos_ff) && phase_ff == PH_IDLE)
      else $error("idle character changed parse state");

   // a range error result always carries the saturated value
   a_range_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == rstu_pkg::ST_RANGE) |-> (value_ff == '1))
      else $error("range error without saturated value");

endmodule
